@@ sv/id3p_pkg.sv @@
// Shared types, codes and helper functions of the ID3v2 text frame parser.
// Depends on nothing; the top level and id3p_step import it.
package id3p_pkg;

	localparam int unsigned ID_CHARS = 4;

	localparam logic [2:0] EV_TAG   = 3'd0;
	localparam logic [2:0] EV_FRAME = 3'd1;
	localparam logic [2:0] EV_CHAR  = 3'd2;
	localparam logic [2:0] EV_NOTAG = 3'd3;
	localparam logic [2:0] EV_END   = 3'd4;

	localparam logic [15:0] MAX_VERSION_RESET = 16'h0300;
	localparam logic [7:0]  BOM_SECOND_FIRST  = 8'hFE;
	localparam logic [31:0] TXXX_IDENT        = 32'h5458_5858;
	localparam logic [7:0]  TEXT_LEAD         = 8'h54;
	localparam logic [3:0]  HDR_LAST          = 4'd9;
	localparam logic [3:0]  FHDR_LAST         = 4'(ID_CHARS + 5);

	typedef enum logic [3:0] {
		PH_HDR   = 4'd0,
		PH_FHDR  = 4'd1,
		PH_ENC   = 4'd2,
		PH_ASCII = 4'd3,
		PH_BOM0  = 4'd4,
		PH_BOM1  = 4'd5,
		PH_PAIR  = 4'd6,
		PH_SKIP  = 4'd7,
		PH_IDLE  = 4'd8
	} phase_t;

	typedef struct packed {
		phase_t      phase;
		logic [3:0]  byte_count;
		logic [15:0] version_word;
		logic [31:0] size_shift;
		logic [31:0] frame_ident;
		logic [31:0] frame_size_word;
		logic [31:0] bytes_left;
		logic        wide_text;
		logic        take_second_byte;
		logic        pair_half;
	} state_t;

	typedef struct packed {
		logic        valid;
		logic [2:0]  event_res;
		logic [31:0] value;
		logic [31:0] frame_length;
		logic        last_of_frame;
	} result_t;

	function automatic logic [7:0] magic_byte(input logic [1:0] k);
		case (k)
			2'd0:    magic_byte = 8'h49;
			2'd1:    magic_byte = 8'h44;
			default: magic_byte = 8'h33;
		endcase
	endfunction

	function automatic logic [31:0] synchsafe(input logic [31:0] s);
		synchsafe = {4'b0, s[30:24], s[22:16], s[14:8], s[6:0]};
	endfunction

	function automatic logic id_char_ok(input logic [7:0] c);
		id_char_ok = c inside {[8'h30:8'h39], [8'h41:8'h5A]};
	endfunction

	function automatic logic text_frame_ok(input logic [31:0] ident);
		logic ok;
		ok = 1'b1;
		for (int i = 0; i < ID_CHARS; i++) begin
			if (!id_char_ok(ident[8*i +: 8]))
				ok = 1'b0;
		end
		if (ident[31:24] != TEXT_LEAD)
			ok = 1'b0;
		if (ident == TXXX_IDENT)
			ok = 1'b0;
		text_frame_ok = ok;
	endfunction

endpackage

@@ sv/id3p_if.sv @@
// Channel interfaces of the ID3v2 text frame parser: byte input, event output
// and the configuration write channel. Depends on nothing.
interface id3p_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       restart;

	modport source (output valid, output data_byte, output restart, input ready);
	modport sink (input valid, input data_byte, input restart, output ready);
endinterface

interface id3p_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  event_res;
	logic [31:0] value;
	logic [31:0] frame_length;
	logic        last_of_frame;

	modport source (output valid, output event_res, output value, output frame_length,
		output last_of_frame, input ready);
	modport sink (input valid, input event_res, input value, input frame_length,
		input last_of_frame, output ready);
endinterface

interface id3p_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] max_version;

	modport source (output valid, output max_version, input ready);
	modport sink (input valid, input max_version, output ready);
endinterface

@@ sv/id3v2_text_frame_parser_unit.sv @@
// Top level of the ID3v2 text frame parser: input register, parse step and
// result register. Depends on id3p_pkg, the interfaces in id3p_if and id3p_step.
//
// Throughput: one byte per cycle while the consumer takes events, whatever the byte stream holds.
// A byte is registered in stage one, passes the single parse step, and its event,
// if any, is registered in the result register, from which the consumer takes
// it. Reset clears the parser state, both stage valids, and loads max_version
// with 0x0300; the block is ready in the cycle after reset.
module id3v2_text_frame_parser_unit (
	input logic        clk,
	input logic        arst_n,
	id3p_in_if.sink    byte_in,
	id3p_out_if.source event_out,
	id3p_cfg_if.sink   cfg
);
	import id3p_pkg::*;

	// Stage one holds the accepted byte; stage two holds the finished event.
	logic        valid_s1;
	logic [7:0]  data_byte_s1;
	logic        restart_s1;
	result_t     res_s2;
	state_t      state_q;
	logic [15:0] max_version_q;

	state_t  state_nxt;
	result_t res_nxt;
	logic    advance;

	// The byte in stage one moves on whenever the result register is empty or is
	// being emptied in this cycle, so a stalled consumer holds one event and one
	// byte and the producer sees ready fall only then.
	assign advance = valid_s1 && (!res_s2.valid || event_out.ready);
	assign byte_in.ready = !valid_s1 || advance;

	// The configuration register is always writable; the user must write it only while
	// the parser is idle, and the block itself does not enforce this.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_version_q <= MAX_VERSION_RESET;
		end else if (cfg.valid) begin
			max_version_q <= cfg.max_version;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_in.valid && byte_in.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_in.valid && byte_in.ready) begin
			data_byte_s1 <= byte_in.data_byte;
			restart_s1 <= byte_in.restart;
		end
	end

	id3p_step u_step (
		.st          (state_q),
		.data_byte   (data_byte_s1),
		.restart     (restart_s1),
		.max_version (max_version_q),
		.nxt         (state_nxt),
		.res         (res_nxt)
	);

	// The parser state only moves when a byte actually passes the step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// A byte that causes no event leaves the result register empty; that is safe
	// because advancing while a result was held implies the result was taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_s2 <= '0;
		end else if (advance) begin
			res_s2 <= res_nxt;
		end else if (event_out.ready) begin
			res_s2.valid <= 1'b0;
		end
	end

	assign event_out.valid = res_s2.valid;
	assign event_out.event_res = res_s2.event_res;
	assign event_out.value = res_s2.value;
	assign event_out.frame_length = res_s2.frame_length;
	assign event_out.last_of_frame = res_s2.last_of_frame;

	// Once parsing has ended only a restart byte can leave the idle phase.
	a_idle_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && state_q.phase == PH_IDLE && !restart_s1) |=> state_q.phase == PH_IDLE)
		else $error("parser left the idle phase without a restart");

	// The header byte counter never runs past the last header byte.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.byte_count <= FHDR_LAST)
		else $error("header byte counter out of range");

	// Events that end parsing must leave the parser idle.
	a_end_idles: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && res_nxt.valid && (res_nxt.event_res == EV_NOTAG
		|| res_nxt.event_res == EV_END)) |=> state_q.phase == PH_IDLE)
		else $error("end event without the idle phase");

	// A byte held in stage one is never dropped while the output is stalled.
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> valid_s1)
		else $error("stalled byte lost from stage one");

	// A pending result is not overwritten while the consumer stalls.
	a_res_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(res_s2.valid && !event_out.ready) |=> res_s2.valid && $stable(res_s2.value))
		else $error("pending result overwritten");

endmodule

@@ sv/id3p_step.sv @@
// Per-byte parse step: next parser state and the optional event for one byte.
// Depends on id3p_pkg for the state, result and phase types.
module id3p_step (
	input  id3p_pkg::state_t  st,
	input  logic [7:0]        data_byte,
	input  logic              restart,
	input  logic [15:0]       max_version,
	output id3p_pkg::state_t  nxt,
	output id3p_pkg::result_t res
);
	import id3p_pkg::*;

	state_t      s;
	logic [31:0] bl_dec;
	logic [15:0] ver;
	logic [31:0] shifted;

	always_comb begin
		s = restart ? '0 : st;
		nxt = s;
		res = '0;
		bl_dec = s.bytes_left - 32'd1;
		ver = {s.version_word[15:8], data_byte};
		shifted = {s.size_shift[23:0], data_byte};

		case (s.phase)
			PH_HDR: begin
				nxt.byte_count = s.byte_count + 4'd1;
				if (s.byte_count < 4'd3) begin
					if (data_byte != magic_byte(s.byte_count[1:0])) begin
						nxt.phase = PH_IDLE;
						res.valid = 1'b1;
						res.event_res = EV_NOTAG;
					end
				end else if (s.byte_count == 4'd3) begin
					nxt.version_word = {data_byte, 8'h00};
				end else if (s.byte_count == 4'd4) begin
					nxt.version_word = ver;
					if (ver > max_version) begin
						nxt.phase = PH_IDLE;
						res.valid = 1'b1;
						res.event_res = EV_NOTAG;
					end
				end else if (s.byte_count >= 4'd6) begin
					nxt.size_shift = shifted;
					if (s.byte_count == HDR_LAST) begin
						nxt.phase = PH_FHDR;
						nxt.byte_count = '0;
						res.valid = 1'b1;
						res.event_res = EV_TAG;
						res.value = synchsafe(shifted);
					end
				end
			end

			PH_FHDR: begin
				nxt.byte_count = s.byte_count + 4'd1;
				if (s.byte_count < 4'(ID_CHARS))
					nxt.frame_ident = {s.frame_ident[23:0], data_byte};
				else if (s.byte_count < 4'(ID_CHARS + 4))
					nxt.frame_size_word = {s.frame_size_word[23:0], data_byte};
				if (s.byte_count >= FHDR_LAST) begin
					nxt.byte_count = '0;
					if (text_frame_ok(s.frame_ident)) begin
						nxt.phase = PH_ENC;
					end else begin
						nxt.phase = PH_IDLE;
						res.valid = 1'b1;
						res.event_res = EV_END;
					end
				end
			end

			PH_ENC: begin
				nxt.bytes_left = s.frame_size_word - 32'd1;
				res.valid = 1'b1;
				res.event_res = EV_FRAME;
				res.value = s.frame_ident;
				res.frame_length = s.frame_size_word;
				if (data_byte == 8'd0 && s.frame_size_word >= 32'd2) begin
					nxt.wide_text = 1'b0;
					nxt.phase = PH_ASCII;
				end else if (data_byte == 8'd1 && s.frame_size_word != 32'd0) begin
					nxt.wide_text = 1'b1;
					if (nxt.bytes_left >= 32'd2)
						nxt.phase = PH_BOM0;
					else if (nxt.bytes_left == 32'd1)
						nxt.phase = PH_SKIP;
					else
						nxt.phase = PH_FHDR;
				end else begin
					nxt.phase = PH_IDLE;
					res.event_res = EV_END;
					res.value = '0;
					res.frame_length = '0;
				end
			end

			PH_ASCII: begin
				nxt.bytes_left = bl_dec;
				if (bl_dec == 32'd0)
					nxt.phase = PH_FHDR;
				res.valid = 1'b1;
				res.event_res = EV_CHAR;
				res.value = {24'h0, data_byte};
				res.last_of_frame = (bl_dec == 32'd0);
			end

			PH_BOM0: begin
				nxt.take_second_byte = (data_byte == BOM_SECOND_FIRST);
				nxt.bytes_left = bl_dec;
				nxt.phase = PH_BOM1;
			end

			PH_BOM1: begin
				nxt.bytes_left = bl_dec;
				nxt.pair_half = 1'b0;
				if (bl_dec >= 32'd2)
					nxt.phase = PH_PAIR;
				else if (bl_dec == 32'd1)
					nxt.phase = PH_SKIP;
				else
					nxt.phase = PH_FHDR;
			end

			PH_PAIR: begin
				nxt.bytes_left = bl_dec;
				nxt.pair_half = ~s.pair_half;
				if (s.pair_half) begin
					if (bl_dec >= 32'd2)
						nxt.phase = PH_PAIR;
					else if (bl_dec == 32'd1)
						nxt.phase = PH_SKIP;
					else
						nxt.phase = PH_FHDR;
				end
				if (s.pair_half == s.take_second_byte) begin
					res.valid = 1'b1;
					res.event_res = EV_CHAR;
					res.value = {24'h0, data_byte};
					res.last_of_frame = s.pair_half ? (s.bytes_left < 32'd3)
						: (s.bytes_left < 32'd4);
				end
			end

			PH_SKIP: begin
				nxt.bytes_left = bl_dec;
				if (bl_dec == 32'd0)
					nxt.phase = PH_FHDR;
			end

			default: begin
				nxt.phase = PH_IDLE;
			end
		endcase
	end

endmodule
